/* rtl/mcgf_pkg.sv */
// ----------------------------------------------------------------------------
// mcgf_pkg
// shared types and constants of the mouse chord gesture filter
// ----------------------------------------------------------------------------
package mcgf_pkg;

  localparam int HOLD_DEPTH = 32;
  localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
  localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);
  localparam int HOLD_W     = 47;
  localparam int OUT_DW     = 96;
  localparam int IN_DW      = 48;

  localparam logic [4:0] EV_KEY       = 5'd1;
  localparam logic [4:0] EV_REL       = 5'd2;
  localparam logic [9:0] CODE_LBUTTON = 10'h110;
  localparam logic [9:0] CODE_RBUTTON = 10'h111;
  localparam logic [9:0] REL_X        = 10'h000;

  localparam logic [15:0] WINDOW_RST = 16'd35;
  localparam logic [15:0] GAIN_RST   = 16'd256;
  localparam logic [15:0] STEP_RST   = 16'd500;
  localparam logic [15:0] GAP_RST    = 16'd120;
  localparam logic [15:0] SINCE_MAX  = 16'hFFFF;

  localparam logic [2:0] REG_CHORD_WINDOW = 3'd0;
  localparam logic [2:0] REG_SWIPE_GAIN   = 3'd1;
  localparam logic [2:0] REG_MOVE_STEP    = 3'd2;
  localparam logic [2:0] REG_MOVE_INVERT  = 3'd3;
  localparam logic [2:0] REG_MOVE_GAP     = 3'd4;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_PENDING = 3'd1,
    MODE_GESTURE = 3'd2,
    MODE_DRAIN   = 3'd3,
    MODE_WMOVE   = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_PASS   = 3'd0,
    KIND_TBEGIN = 3'd1,
    KIND_TMOVE  = 3'd2,
    KIND_TEND   = 3'd3,
    KIND_JUMP   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_REPLAY,
    ST_TAIL
  } state_e;

  typedef struct packed {
    logic live;
    logic tbegin;
    logic jump;
    logic tmove;
    logic tend;
  } tail_t;

endpackage

/* rtl/mouse_chord_gesture_filter_unit.sv */
// ----------------------------------------------------------------------------
// mouse_chord_gesture_filter_unit
// filters mouse events into pass, touchpad gesture and window-jump results
// ----------------------------------------------------------------------------
// One input transaction (an event or a millisecond tick) is taken into the
// block and evaluated in the following cycle. Events held while a press is
// pending sit in a one-port hold memory of 32 entries; each replayed entry
// takes a memory read, then the load of the output register, and every other
// result is loaded into the output register directly. The next transaction is
// accepted as soon as the final result of the current one sits in the output
// register, while that result still waits.
module mouse_chord_gesture_filter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // event_type, event_code, event_value, modifier_held
  input  logic [mcgf_pkg::IN_DW-1:0]   s_axis_tdata_i,
  // command
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // out_type, out_code, out_value, touch_delta, jump_right
  output logic [mcgf_pkg::OUT_DW-1:0]  m_axis_tdata_o,
  // result_kind
  output logic [2:0]                   m_axis_tuser_o,
  output logic                         m_axis_tlast_o,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [4:0]                   paddr_i,
  input  logic [31:0]                  pwdata_i,
  output logic [31:0]                  prdata_o,
  output logic                         pready_o
);

  localparam int AW = mcgf_pkg::HOLD_AW;
  localparam int CW = mcgf_pkg::CNT_W;
  localparam int HW = mcgf_pkg::HOLD_W;
  localparam int DW = mcgf_pkg::OUT_DW;

  // configuration
  logic [15:0] cfg_window_q, cfg_gain_q, cfg_step_q, cfg_gap_q;
  logic        cfg_invert_q;
  logic        cfg_wr;

  // input transaction
  logic              cmd_q, mod_q;
  logic [4:0]        type_q;
  logic [9:0]        code_q;
  logic signed [31:0] value_q;

  // filter state
  mcgf_pkg::mode_e   mode_q, mode_d;
  logic              left_q, left_d, right_q, right_d;
  logic [CW-1:0]     count_q, count_d;
  logic [15:0]       window_q, window_d;
  logic signed [16:0] sum_q, sum_d;
  logic [15:0]       since_q, since_d;

  // result sequencing
  mcgf_pkg::state_e  state_q, state_d;
  logic [CW-1:0]     rpl_n_q, rpl_n_d, rpl_idx_q;
  mcgf_pkg::tail_t   tail_q, tail_d, tail_next;
  logic signed [47:0] delta_q, delta_d;
  logic              jdir_q, jdir_d;

  // hold memory
  logic [HW-1:0]     hold_mem [mcgf_pkg::HOLD_DEPTH];
  logic [HW-1:0]     rd_data_q, mem_wd;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;

  // output register
  logic              m_valid_q, m_last_q;
  logic [2:0]        m_kind_q;
  logic [DW-1:0]     m_data_q;

  // control
  logic              eval_en, rd_en, slot_free, rpl_emit, tail_emit, rpl_done;
  logic [2:0]        tail_kind;
  logic [DW-1:0]     tail_data;

  // ---------------------------------------------------------------- config
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_window_q <= mcgf_pkg::WINDOW_RST;
      cfg_gain_q   <= mcgf_pkg::GAIN_RST;
      cfg_step_q   <= mcgf_pkg::STEP_RST;
      cfg_invert_q <= 1'b0;
      cfg_gap_q    <= mcgf_pkg::GAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr_i[4:2])
        mcgf_pkg::REG_CHORD_WINDOW: cfg_window_q <= pwdata_i[15:0];
        mcgf_pkg::REG_SWIPE_GAIN:   cfg_gain_q   <= pwdata_i[15:0];
        mcgf_pkg::REG_MOVE_STEP:    cfg_step_q   <= pwdata_i[15:0];
        mcgf_pkg::REG_MOVE_INVERT:  cfg_invert_q <= pwdata_i[0];
        mcgf_pkg::REG_MOVE_GAP:     cfg_gap_q    <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      mcgf_pkg::REG_CHORD_WINDOW: prdata_o = {16'd0, cfg_window_q};
      mcgf_pkg::REG_SWIPE_GAIN:   prdata_o = {16'd0, cfg_gain_q};
      mcgf_pkg::REG_MOVE_STEP:    prdata_o = {16'd0, cfg_step_q};
      mcgf_pkg::REG_MOVE_INVERT:  prdata_o = {31'd0, cfg_invert_q};
      mcgf_pkg::REG_MOVE_GAP:     prdata_o = {16'd0, cfg_gap_q};
      default:                    prdata_o = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- control
  assign slot_free = !m_valid_q || m_axis_tready_i;
  assign rpl_done  = (CW'(rpl_idx_q + 1'b1) == rpl_n_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mcgf_pkg::ST_IDLE:   if (s_axis_tvalid_i) state_d = mcgf_pkg::ST_EVAL;
      mcgf_pkg::ST_EVAL: begin
        if (rpl_n_d != '0)      state_d = mcgf_pkg::ST_READ;
        else if (tail_d != '0)  state_d = mcgf_pkg::ST_TAIL;
        else                    state_d = mcgf_pkg::ST_IDLE;
      end
      mcgf_pkg::ST_READ:   state_d = mcgf_pkg::ST_REPLAY;
      mcgf_pkg::ST_REPLAY: begin
        if (slot_free) begin
          if (!rpl_done)          state_d = mcgf_pkg::ST_READ;
          else if (tail_q != '0)  state_d = mcgf_pkg::ST_TAIL;
          else                    state_d = mcgf_pkg::ST_IDLE;
        end
      end
      mcgf_pkg::ST_TAIL:   if (slot_free && tail_next == '0) state_d = mcgf_pkg::ST_IDLE;
      default:             state_d = mcgf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == mcgf_pkg::ST_IDLE);
    eval_en         = (state_q == mcgf_pkg::ST_EVAL);
    rd_en           = (state_q == mcgf_pkg::ST_READ);
    rpl_emit        = (state_q == mcgf_pkg::ST_REPLAY) && slot_free;
    tail_emit       = (state_q == mcgf_pkg::ST_TAIL) && slot_free;
  end

  // tail results in emission order
  always_comb begin
    tail_next = tail_q;
    tail_kind = mcgf_pkg::KIND_PASS;
    tail_data = '0;
    priority if (tail_q.live) begin
      tail_next.live = 1'b0;
      tail_kind      = mcgf_pkg::KIND_PASS;
      tail_data      = {49'd0, value_q, code_q, type_q};
    end else if (tail_q.tbegin) begin
      tail_next.tbegin = 1'b0;
      tail_kind        = mcgf_pkg::KIND_TBEGIN;
    end else if (tail_q.jump) begin
      tail_next.jump = 1'b0;
      tail_kind      = mcgf_pkg::KIND_JUMP;
      tail_data      = {jdir_q, 95'd0};
    end else if (tail_q.tmove) begin
      tail_next.tmove = 1'b0;
      tail_kind       = mcgf_pkg::KIND_TMOVE;
      tail_data       = {1'b0, delta_q, 47'd0};
    end else if (tail_q.tend) begin
      tail_next.tend = 1'b0;
      tail_kind      = mcgf_pkg::KIND_TEND;
    end else begin
      tail_next = tail_q;
    end
  end

  // ---------------------------------------------------------------- evaluate
  logic               is_btn, is_x, is_left, is_right, chord_was, chord_is;
  logic signed [33:0] val_ext, sum_new, step_ext;
  logic               over_step;

  always_comb begin
    is_left   = (type_q == mcgf_pkg::EV_KEY) && (code_q == mcgf_pkg::CODE_LBUTTON);
    is_right  = (type_q == mcgf_pkg::EV_KEY) && (code_q == mcgf_pkg::CODE_RBUTTON);
    is_btn    = is_left || is_right;
    is_x      = (type_q == mcgf_pkg::EV_REL) && (code_q == mcgf_pkg::REL_X);
    val_ext   = {{2{value_q[31]}}, value_q};
    step_ext  = {18'd0, cfg_step_q};
    sum_new   = {{17{sum_q[16]}}, sum_q} + (cfg_invert_q ? -val_ext : val_ext);
    over_step = (sum_new >= step_ext) || (sum_new <= -step_ext);
    delta_d   = value_q * $signed({1'b0, cfg_gain_q});

    mode_d    = mode_q;
    left_d    = left_q;
    right_d   = right_q;
    count_d   = count_q;
    window_d  = window_q;
    sum_d     = sum_q;
    since_d   = since_q;
    rpl_n_d   = '0;
    tail_d    = '0;
    jdir_d    = jdir_q;
    mem_we    = 1'b0;
    mem_wa    = count_q[AW-1:0];
    mem_wd    = {value_q, code_q, type_q};
    chord_was = left_q && right_q;
    chord_is  = chord_was;

    if (cmd_q) begin
      if (since_q != mcgf_pkg::SINCE_MAX) since_d = since_q + 16'd1;
      if (mode_q == mcgf_pkg::MODE_PENDING) begin
        if (window_q <= 16'd1) begin
          window_d = '0;
          rpl_n_d  = count_q;
          count_d  = '0;
          mode_d   = mcgf_pkg::MODE_NORMAL;
        end else begin
          window_d = window_q - 16'd1;
        end
      end
    end else begin
      if (is_left)  left_d  = (value_q != 32'sd0);
      if (is_right) right_d = (value_q != 32'sd0);
      chord_is = left_d && right_d;
      unique case (mode_q)
        mcgf_pkg::MODE_PENDING: begin
          if (!chord_was && chord_is) begin
            count_d  = '0;
            window_d = '0;
            if (mod_q) begin
              mode_d  = mcgf_pkg::MODE_WMOVE;
              sum_d   = '0;
              since_d = mcgf_pkg::SINCE_MAX;
            end else begin
              mode_d        = mcgf_pkg::MODE_GESTURE;
              tail_d.tbegin = 1'b1;
            end
          end else if (is_btn && value_q == 32'sd0) begin
            window_d    = '0;
            rpl_n_d     = count_q;
            tail_d.live = 1'b1;
            count_d     = '0;
            mode_d      = mcgf_pkg::MODE_NORMAL;
          end else if (count_q == CW'(mcgf_pkg::HOLD_DEPTH)) begin
            rpl_n_d     = count_q;
            tail_d.live = 1'b1;
            count_d     = '0;
          end else begin
            mem_we  = 1'b1;
            count_d = CW'(count_q + 1'b1);
          end
        end
        mcgf_pkg::MODE_GESTURE: begin
          tail_d.tmove = is_x;
          if (!chord_is) begin
            tail_d.tend = 1'b1;
            mode_d      = mcgf_pkg::MODE_DRAIN;
          end
        end
        mcgf_pkg::MODE_WMOVE: begin
          if (is_x) begin
            if (over_step) begin
              if (since_q >= cfg_gap_q) begin
                tail_d.jump = 1'b1;
                jdir_d      = (sum_new > 34'sd0);
                since_d     = '0;
              end
              sum_d = '0;
            end else begin
              sum_d = 17'(sum_new);
            end
          end
          if (!chord_is) mode_d = mcgf_pkg::MODE_DRAIN;
        end
        mcgf_pkg::MODE_DRAIN: begin
          if (!left_d && !right_d) mode_d = mcgf_pkg::MODE_NORMAL;
        end
        default: begin
          mode_d = mcgf_pkg::MODE_NORMAL;
          if (is_btn && value_q == 32'sd1) begin
            mode_d   = mcgf_pkg::MODE_PENDING;
            mem_we   = 1'b1;
            mem_wa   = '0;
            count_d  = CW'(1);
            window_d = cfg_window_q;
          end else begin
            tail_d.live = 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mcgf_pkg::ST_IDLE;
      mode_q    <= mcgf_pkg::MODE_NORMAL;
      left_q    <= 1'b0;
      right_q   <= 1'b0;
      count_q   <= '0;
      window_q  <= '0;
      sum_q     <= '0;
      since_q   <= mcgf_pkg::SINCE_MAX;
      rpl_n_q   <= '0;
      rpl_idx_q <= '0;
      tail_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (eval_en) begin
        mode_q    <= mode_d;
        left_q    <= left_d;
        right_q   <= right_d;
        count_q   <= count_d;
        window_q  <= window_d;
        sum_q     <= sum_d;
        since_q   <= since_d;
        rpl_n_q   <= rpl_n_d;
        rpl_idx_q <= '0;
        tail_q    <= tail_d;
      end else if (rpl_emit) begin
        rpl_idx_q <= CW'(rpl_idx_q + 1'b1);
      end else if (tail_emit) begin
        tail_q <= tail_next;
      end
      if (rpl_emit || tail_emit) m_valid_q <= 1'b1;
      else if (m_axis_tready_i)  m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q   <= s_axis_tuser_i;
      type_q  <= s_axis_tdata_i[4:0];
      code_q  <= s_axis_tdata_i[14:5];
      value_q <= s_axis_tdata_i[46:15];
      mod_q   <= s_axis_tdata_i[47];
    end
    if (eval_en) begin
      delta_q <= delta_d;
      jdir_q  <= jdir_d;
    end
    if (rpl_emit) begin
      m_kind_q <= mcgf_pkg::KIND_PASS;
      m_data_q <= {49'd0, rd_data_q};
      m_last_q <= rpl_done && (tail_q == '0);
    end else if (tail_emit) begin
      m_kind_q <= tail_kind;
      m_data_q <= tail_data;
      m_last_q <= (tail_next == '0);
    end
  end

  // hold memory, one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (eval_en && mem_we) hold_mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_q <= hold_mem[rpl_idx_q[AW-1:0]];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* tb/tb_mouse_chord_gesture_filter_unit.sv */
// ----------------------------------------------------------------------------
// tb_mouse_chord_gesture_filter_unit
// self-checking testbench of the mouse chord gesture filter
// ----------------------------------------------------------------------------
// Sends mouse events and millisecond ticks into the stream input. A shadow
// copy of the filter state predicts the results of each accepted transaction,
// and every result is checked in order. The run steps through several register
// settings, the extremes among them. The first gets directed chords and
// clicks; each gets random gesture, click, window-expiry and buffer-overflow
// sequences mixed with noise. Source idling and sink stalling change from one
// setting to the next.
// ----------------------------------------------------------------------------
module tb_mouse_chord_gesture_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mcgf_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_GOAL   = 450;
  localparam int NUM_PHASES  = 7;
  localparam int MAX_PRINTS  = 30;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  ev_type;
    logic [9:0]  ev_code;
    logic [31:0] ev_value;
    logic [47:0] delta;
    logic        right;
    logic        last;
  } filter_result_t;

  class chord_filter_shadow;
    logic [15:0]    window_cfg, gain_cfg, step_cfg, gap_cfg;
    logic           invert_cfg;
    mode_e          mode;
    bit             left_dn, right_dn;
    logic [46:0]    held_events[$];
    logic [15:0]    window_left;
    longint         motion_sum;
    logic [15:0]    since_jump;
    filter_result_t due_results[$];
    filter_result_t item_results[$];
    int             errors, items, ticks;
    int             kind_cnt[5];

    function new();
      window_cfg  = WINDOW_RST;
      gain_cfg    = GAIN_RST;
      step_cfg    = STEP_RST;
      invert_cfg  = 1'b0;
      gap_cfg     = GAP_RST;
      mode        = MODE_NORMAL;
      left_dn     = 1'b0;
      right_dn    = 1'b0;
      window_left = '0;
      motion_sum  = 0;
      since_jump  = SINCE_MAX;
      errors      = 0;
      items       = 0;
      ticks       = 0;
      foreach (kind_cnt[i]) kind_cnt[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_CHORD_WINDOW: window_cfg = data[15:0];
        REG_SWIPE_GAIN:   gain_cfg   = data[15:0];
        REG_MOVE_STEP:    step_cfg   = data[15:0];
        REG_MOVE_INVERT:  invert_cfg = data[0];
        REG_MOVE_GAP:     gap_cfg    = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_CHORD_WINDOW: return {16'd0, window_cfg};
        REG_SWIPE_GAIN:   return {16'd0, gain_cfg};
        REG_MOVE_STEP:    return {16'd0, step_cfg};
        REG_MOVE_INVERT:  return {31'd0, invert_cfg};
        REG_MOVE_GAP:     return {16'd0, gap_cfg};
        default:          return '0;
      endcase
    endfunction

    function void emit(kind_e k, logic [46:0] ev, logic [47:0] delta, logic right);
      filter_result_t r;
      r.kind     = k;
      r.ev_type  = ev[4:0];
      r.ev_code  = ev[14:5];
      r.ev_value = ev[46:15];
      r.delta    = delta;
      r.right    = right;
      r.last     = 1'b0;
      item_results.push_back(r);
    endfunction

    function void replay();
      foreach (held_events[i]) emit(KIND_PASS, held_events[i], '0, 1'b0);
      held_events.delete();
    endfunction

    function void hold(logic [46:0] ev);
      if (held_events.size() < HOLD_DEPTH) begin
        held_events.push_back(ev);
      end else begin
        replay();
        emit(KIND_PASS, ev, '0, 1'b0);
      end
    endfunction

    function void take_item(logic tick, logic [4:0] ev_type, logic [9:0] ev_code,
                            logic [31:0] ev_value, logic modifier);
      logic [46:0] ev;
      bit          is_btn, is_x, chord_was, chord_is;
      longint      dv, prod, lim;
      items++;
      item_results.delete();
      if (tick) begin
        ticks++;
        if (since_jump != SINCE_MAX) since_jump++;
        if (mode == MODE_PENDING) begin
          if (window_left <= 16'd1) begin
            window_left = '0;
            replay();
            mode = MODE_NORMAL;
          end else begin
            window_left--;
          end
        end
      end else begin
        ev     = {ev_value, ev_code, ev_type};
        is_btn = (ev_type == EV_KEY) &&
                 (ev_code == CODE_LBUTTON || ev_code == CODE_RBUTTON);
        is_x   = (ev_type == EV_REL) && (ev_code == REL_X);
        chord_was = left_dn && right_dn;
        if (ev_type == EV_KEY && ev_code == CODE_LBUTTON) left_dn  = (ev_value != 0);
        if (ev_type == EV_KEY && ev_code == CODE_RBUTTON) right_dn = (ev_value != 0);
        chord_is = left_dn && right_dn;
        case (mode)
          MODE_PENDING: begin
            if (!chord_was && chord_is) begin
              held_events.delete();
              window_left = '0;
              if (modifier) begin
                mode       = MODE_WMOVE;
                motion_sum = 0;
                since_jump = SINCE_MAX;
              end else begin
                mode = MODE_GESTURE;
                emit(KIND_TBEGIN, '0, '0, 1'b0);
              end
            end else if (is_btn && ev_value == 0) begin
              window_left = '0;
              hold(ev);
              replay();
              mode = MODE_NORMAL;
            end else begin
              hold(ev);
            end
          end
          MODE_GESTURE: begin
            if (is_x) begin
              prod = longint'($signed(ev_value)) * longint'(gain_cfg);
              emit(KIND_TMOVE, '0, prod[47:0], 1'b0);
            end
            if (!chord_is) begin
              emit(KIND_TEND, '0, '0, 1'b0);
              mode = MODE_DRAIN;
            end
          end
          MODE_WMOVE: begin
            if (is_x) begin
              dv = longint'($signed(ev_value));
              if (invert_cfg) dv = -dv;
              motion_sum += dv;
              lim = longint'(step_cfg);
              if (motion_sum >= lim || motion_sum <= -lim) begin
                if (since_jump >= gap_cfg) begin
                  emit(KIND_JUMP, '0, '0, motion_sum > 0);
                  since_jump = '0;
                end
                motion_sum = 0;
              end
            end
            if (!chord_is) mode = MODE_DRAIN;
          end
          MODE_DRAIN: begin
            if (!left_dn && !right_dn) mode = MODE_NORMAL;
          end
          default: begin
            mode = MODE_NORMAL;
            if (is_btn && ev_value == 32'd1) begin
              mode = MODE_PENDING;
              held_events.delete();
              hold(ev);
              window_left = window_cfg;
            end else begin
              emit(KIND_PASS, ev, '0, 1'b0);
            end
          end
        endcase
      end
      if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
      foreach (item_results[i]) due_results.push_back(item_results[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task match_result(filter_result_t got);
      filter_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result of kind %0d with none outstanding", got.kind));
        return;
      end
      want = due_results.pop_front();
      kind_cnt[int'(want.kind)]++;
      if (got.kind !== want.kind)
        report($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
      if (got.ev_type !== want.ev_type)
        report($sformatf("out_type %h, expected %h", got.ev_type, want.ev_type));
      if (got.ev_code !== want.ev_code)
        report($sformatf("out_code %h, expected %h", got.ev_code, want.ev_code));
      if (got.ev_value !== want.ev_value)
        report($sformatf("out_value %h, expected %h", got.ev_value, want.ev_value));
      if (got.delta !== want.delta)
        report($sformatf("touch_delta %h, expected %h", got.delta, want.delta));
      if (got.right !== want.right)
        report($sformatf("jump_right %b, expected %b", got.right, want.right));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  // event_type, event_code, event_value, modifier_held
  logic [IN_DW-1:0]    s_tdata   = '0;
  // command
  logic                s_tuser   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  // out_type, out_code, out_value, touch_delta, jump_right
  logic [OUT_DW-1:0]   m_tdata;
  // result_kind
  logic [2:0]          m_tuser;
  logic                m_tlast;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [4:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  chord_filter_shadow  shadow;
  int                  items_sent = 0;
  int                  idle_pct   = 0;
  int                  stall_pct  = 0;
  int                  quiet_cycles = 0;

  mouse_chord_gesture_filter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid && s_tready)
      shadow.take_item(s_tuser, s_tdata[4:0], s_tdata[14:5], s_tdata[46:15], s_tdata[47]);
  end

  always @(posedge clk_i) begin
    filter_result_t got;
    if (rst_ni && m_tvalid && m_tready) begin
      got.kind     = kind_e'(m_tuser);
      got.ev_type  = m_tdata[4:0];
      got.ev_code  = m_tdata[14:5];
      got.ev_value = m_tdata[46:15];
      got.delta    = m_tdata[94:47];
      got.right    = m_tdata[95];
      got.last     = m_tlast;
      shadow.match_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(input logic tick, input logic [4:0] ty, input logic [9:0] code,
                           input logic [31:0] val, input logic modifier);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= tick;
    s_tdata  <= {modifier, val, code, ty};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic ev(input logic [4:0] ty, input logic [9:0] code, input logic [31:0] val,
                    input logic modifier);
    send_item(1'b0, ty, code, val, modifier);
  endtask

  task automatic tick_item();
    send_item(1'b1, 5'($urandom()), 10'($urandom()), $urandom(), 1'($urandom()));
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow.set_reg(idx, data);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== shadow.reg_value(idx))
      shadow.report($sformatf("register %0d reads %h, written %h", idx, got,
                              shadow.reg_value(idx)));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apply_phase(input int p);
    case (p)
      0: ;
      1: begin
        cfg_write(REG_CHORD_WINDOW, 32'd0);
        cfg_write(REG_SWIPE_GAIN, 32'd65535);
        cfg_write(REG_MOVE_STEP, 32'd1);
        cfg_write(REG_MOVE_INVERT, 32'd1);
        cfg_write(REG_MOVE_GAP, 32'd0);
      end
      2: begin
        cfg_write(REG_CHORD_WINDOW, 32'd65535);
        cfg_write(REG_SWIPE_GAIN, 32'd0);
        cfg_write(REG_MOVE_STEP, 32'd65535);
        cfg_write(REG_MOVE_INVERT, 32'd0);
        cfg_write(REG_MOVE_GAP, 32'd65535);
      end
      6: begin
        cfg_write(REG_CHORD_WINDOW, 32'd5);
        cfg_write(REG_SWIPE_GAIN, 32'd1);
        cfg_write(REG_MOVE_STEP, 32'd100);
        cfg_write(REG_MOVE_INVERT, 32'd1);
        cfg_write(REG_MOVE_GAP, 32'd3);
      end
      default: begin
        cfg_write(REG_CHORD_WINDOW, $urandom_range(1, 40));
        cfg_write(REG_SWIPE_GAIN, $urandom_range(0, 65535));
        cfg_write(REG_MOVE_STEP, $urandom_range(1, 1500));
        cfg_write(REG_MOVE_INVERT, $urandom_range(0, 1));
        cfg_write(REG_MOVE_GAP, $urandom_range(0, 60));
      end
    endcase
    case (p % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 64; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 64; end
      default: begin idle_pct = 29; stall_pct = 29; end
    endcase
  endtask

  function automatic logic [31:0] motion_counts();
    int unsigned mag;
    if ($urandom_range(0, 3) == 0) return $urandom();
    mag = $urandom_range(0, 2 * int'(shadow.step_cfg) + 2);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [9:0] pick_button();
    return $urandom_range(0, 1) ? CODE_LBUTTON : CODE_RBUTTON;
  endfunction

  function automatic logic [9:0] other_button(input logic [9:0] btn);
    return (btn == CODE_LBUTTON) ? CODE_RBUTTON : CODE_LBUTTON;
  endfunction

  // anything but a left or right key event
  task automatic filler(input bit ticks_ok);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 || (r >= 8 && !ticks_ok))
      ev(EV_REL, REL_X, motion_counts(), 1'($urandom_range(0, 1)));
    else if (r < 7)
      ev(EV_REL, 10'($urandom_range(1, 1023)), $urandom(), 1'($urandom_range(0, 1)));
    else if (r == 7)
      ev(EV_KEY, 10'($urandom_range(0, 10'h10F)), $urandom_range(0, 2),
         1'($urandom_range(0, 1)));
    else
      tick_item();
  endtask

  task automatic chord_sequence();
    logic [9:0] first, second, up;
    first  = pick_button();
    second = other_button(first);
    ev(EV_KEY, first, 32'd1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 3)) filler(shadow.window_cfg > 8);
    ev(EV_KEY, second, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 255) : 1,
       1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 8)) filler(1'b1);
    up = pick_button();
    ev(EV_KEY, up, 32'd0, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) filler(1'b1);
    ev(EV_KEY, other_button(up), 32'd0, 1'($urandom_range(0, 1)));
  endtask

  task automatic click_sequence();
    logic [9:0] btn;
    btn = pick_button();
    ev(EV_KEY, btn, 32'd1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 2)) filler(shadow.window_cfg > 8);
    ev(EV_KEY, btn, 32'd0, 1'($urandom_range(0, 1)));
  endtask

  task automatic expire_sequence();
    if (shadow.window_cfg > 64) begin
      click_sequence();
    end else begin
      ev(EV_KEY, pick_button(), 32'd1, 1'($urandom_range(0, 1)));
      repeat (int'(shadow.window_cfg) + 1) begin
        if ($urandom_range(0, 3) == 0) filler(1'b0);
        tick_item();
      end
    end
  endtask

  task automatic overflow_sequence();
    logic [9:0] btn;
    btn = pick_button();
    ev(EV_KEY, btn, 32'd1, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(HOLD_DEPTH, HOLD_DEPTH + 4)) filler(1'b0);
    ev(EV_KEY, btn, 32'd0, 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_sequence();
    logic [4:0]  ty;
    logic [9:0]  code;
    logic [31:0] val;
    int          pick;
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) ty = 5'($urandom_range(0, 31));
      else ty = $urandom_range(0, 1) ? EV_KEY : EV_REL;
      if ($urandom_range(0, 1)) code = 10'($urandom_range(0, 1023));
      else code = (pick == 0) ? REL_X : pick_button();
      val = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1);
      send_item($urandom_range(0, 3) == 0, ty, code, val, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) chord_sequence();
    else if (r < 52) click_sequence();
    else if (r < 62) expire_sequence();
    else if (r < 65) overflow_sequence();
    else noise_sequence();
  endtask

  task automatic directed_items();
    ev(5'h1F, 10'h3FF, 32'h8000_0000, 1'b1);
    ev(5'h00, 10'h000, 32'h7FFF_FFFF, 1'b0);
    send_item(1'b1, 5'h1F, 10'h3FF, 32'hFFFF_FFFF, 1'b1);
    // non-press value still marks the button held
    ev(EV_KEY, CODE_LBUTTON, 32'd2, 1'b0);
    ev(EV_KEY, CODE_LBUTTON, 32'd0, 1'b0);
    // touch swipe
    ev(EV_KEY, CODE_LBUTTON, 32'd1, 1'b0);
    ev(EV_KEY, CODE_RBUTTON, 32'd1, 1'b0);
    ev(EV_REL, REL_X, 32'd3, 1'b0);
    ev(EV_REL, REL_X, 32'h8000_0000, 1'b1);
    ev(EV_REL, 10'h001, 32'd7, 1'b0);
    ev(EV_KEY, CODE_RBUTTON, 32'd0, 1'b0);
    ev(EV_KEY, CODE_LBUTTON, 32'd0, 1'b0);
    // quick click
    ev(EV_KEY, CODE_RBUTTON, 32'd1, 1'b0);
    ev(EV_REL, REL_X, 32'd5, 1'b0);
    ev(EV_KEY, CODE_RBUTTON, 32'd0, 1'b0);
    // window move
    ev(EV_KEY, CODE_RBUTTON, 32'd1, 1'b0);
    ev(EV_KEY, CODE_LBUTTON, 32'd1, 1'b1);
    ev(EV_REL, REL_X, 32'd600, 1'b0);
    ev(EV_REL, REL_X, -32'sd600, 1'b0);
    tick_item();
    ev(EV_KEY, CODE_LBUTTON, 32'd0, 1'b0);
    ev(EV_REL, REL_X, 32'd900, 1'b0);
    ev(EV_KEY, CODE_RBUTTON, 32'd0, 1'b0);
  endtask

  initial begin
    shadow = new();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_phase(p);
      if (p == 0) directed_items();
      while (items_sent < ITEM_GOAL * (p + 1) / NUM_PHASES) random_sequence();
      settle();
    end
    repeat (16) @(negedge clk_i);
    $display("covered %0d input transactions (%0d ticks) over %0d register settings",
             shadow.items, shadow.ticks, NUM_PHASES);
    $display("results: %0d pass, %0d begin, %0d move, %0d end, %0d jump",
             shadow.kind_cnt[0], shadow.kind_cnt[1], shadow.kind_cnt[2],
             shadow.kind_cnt[3], shadow.kind_cnt[4]);
    if (shadow.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* mouse_chord_gesture_filter_unit.f */
rtl/mcgf_pkg.sv
rtl/mouse_chord_gesture_filter_unit.sv
tb/tb_mouse_chord_gesture_filter_unit.sv
